// ===== rtl/adq_pkg.sv =====
// Shared types, codes and sizes of the array deque unit.
// No dependencies; every other file of the unit but adq_ram imports this package.
`default_nettype none

package adq_pkg;

    localparam int ADQ_DEPTH = 16;
    localparam int ADQ_DW    = 32;

    localparam logic [1:0] OP_PUSH_REAR  = 2'd0;
    localparam logic [1:0] OP_PUSH_FRONT = 2'd1;
    localparam logic [1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [1:0] OP_POP_REAR   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;

    typedef struct packed {
        logic [1:0]               kind;
        logic signed [ADQ_DW-1:0] value;
    } t_req;

    typedef struct packed {
        logic signed [ADQ_DW-1:0] popped;
        logic [1:0]               status;
        logic                     is_empty;
        logic                     is_full;
    } t_rsp;

    typedef struct packed {
        logic take;
        logic fill;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
        logic rd_pop;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/adq_if.sv =====
// Valid/ready channel interfaces for the request and response beats.
// Depends on adq_pkg for the payload types.
`default_nettype none

interface adq_req_if;
    import adq_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface adq_rsp_if;
    import adq_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/adq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module adq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/adq_ctrl.sv =====
// Controller of the array deque unit: accepts request beats and sequences
// the storage read of a pop. Depends on adq_pkg.
`default_nettype none

module adq_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_req_valid,
    output logic                  o_req_ready,
    input  wire adq_pkg::t_dp_sts i_sts,
    output adq_pkg::t_dp_cmd      o_cmd
);
    import adq_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        o_req_ready = (r_state == S_IDLE) && !i_sts.out_busy;
        o_cmd.take  = i_req_valid && o_req_ready;
        o_cmd.fill  = (r_state == S_READ);
        n_state     = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.take && i_sts.rd_pop) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_no_take_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !o_cmd.take)
        else $error("request taken during storage read");

    a_pop_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.take && i_sts.rd_pop) |=> o_cmd.fill)
        else $error("pop not followed by fill");

    a_read_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fill |=> !o_cmd.fill)
        else $error("read state held longer than one cycle");

endmodule

`default_nettype wire

// ===== rtl/adq_dp.sv =====
// Datapath of the array deque unit: indices, storage RAM and the result
// register. Depends on adq_pkg and adq_ram.
`default_nettype none

module adq_dp #(
    parameter int DEPTH = adq_pkg::ADQ_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire adq_pkg::t_req    i_req_data,
    input  wire adq_pkg::t_dp_cmd i_cmd,
    output adq_pkg::t_dp_sts      o_sts,
    output logic                  o_rsp_valid,
    input  wire logic             i_rsp_ready,
    output adq_pkg::t_rsp         o_rsp_data
);
    import adq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] C_DEPTH = CW'(DEPTH);
    localparam logic [CW-1:0] C_ONE   = CW'(1);

    // The rear index is held plus one (0 stands for minus one); the front index is held as it is.
    logic [CW-1:0]     r_front;
    logic [CW-1:0]     r_rear;
    logic [CW-1:0]     n_front;
    logic [CW-1:0]     n_rear;
    logic [CW-1:0]     w_front_dec;
    logic [CW-1:0]     w_rear_dec;
    logic              w_empty;
    logic              w_full;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [AW-1:0]     w_raddr;
    logic [ADQ_DW-1:0] w_rdata;
    logic [1:0]        w_status;
    logic [ADQ_DW-1:0] w_popped;
    logic              r_out_vld;
    logic              n_out_vld;
    t_rsp              r_out;
    t_rsp              n_out;

    assign w_empty     = (r_front == r_rear);
    assign w_full      = (r_rear == C_DEPTH);
    assign w_front_dec = r_front - C_ONE;
    assign w_rear_dec  = r_rear - C_ONE;

    always_comb begin
        n_front        = r_front;
        n_rear         = r_rear;
        w_we           = 1'b0;
        w_waddr        = r_rear[AW-1:0];
        w_raddr        = r_front[AW-1:0];
        w_status       = ST_OK;
        w_popped       = '0;
        o_sts.rd_pop   = 1'b0;
        o_sts.out_busy = r_out_vld && !i_rsp_ready;
        case (i_req_data.kind)
            OP_PUSH_REAR: begin
                if (w_full) begin
                    w_status = ST_REFUSED;
                end else begin
                    w_we   = 1'b1;
                    n_rear = r_rear + C_ONE;
                end
            end
            OP_PUSH_FRONT: begin
                if (r_front == '0) begin
                    w_status = ST_REFUSED;
                end else begin
                    w_we    = 1'b1;
                    w_waddr = w_front_dec[AW-1:0];
                    n_front = w_front_dec;
                end
            end
            OP_POP_FRONT: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                    w_popped = '1;
                end else begin
                    o_sts.rd_pop = 1'b1;
                    n_front      = r_front + C_ONE;
                end
            end
            OP_POP_REAR: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                    w_popped = '1;
                end else begin
                    o_sts.rd_pop = 1'b1;
                    w_raddr      = w_rear_dec[AW-1:0];
                    n_rear       = w_rear_dec;
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    always_comb begin
        n_out     = r_out;
        n_out_vld = r_out_vld && !i_rsp_ready;
        if (i_cmd.fill) begin
            n_out.popped   = w_rdata;
            n_out.status   = ST_OK;
            n_out.is_empty = w_empty;
            n_out.is_full  = w_full;
            n_out_vld      = 1'b1;
        end else if (i_cmd.take && !o_sts.rd_pop) begin
            n_out.popped   = w_popped;
            n_out.status   = w_status;
            n_out.is_empty = (n_front == n_rear);
            n_out.is_full  = (n_rear == C_DEPTH);
            n_out_vld      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front   <= '0;
            r_rear    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
            if (i_cmd.take) begin
                r_front <= n_front;
                r_rear  <= n_rear;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    adq_ram #(
        .WIDTH (ADQ_DW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.take && w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_req_data.value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_rsp_valid = r_out_vld;
    assign o_rsp_data  = r_out;

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_front <= r_rear)
        else $error("front index passed rear index");

    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rear <= C_DEPTH)
        else $error("rear index beyond storage");

    a_fill_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fill |-> !o_sts.out_busy)
        else $error("fill into occupied result register");

endmodule

`default_nettype wire

// ===== rtl/array_double_ended_queue_unit.sv =====
// Array deque unit: a linear, non-wrapping double-ended queue of DEPTH signed
// 32-bit entries. A successful pop reads the storage RAM, whose read port is
// registered, and fills the output register in a READ state, in which no
// request is taken. A result beat waits in that output register, and the next
// request is taken in the same cycle that the waiting result is taken. Storage
// needs no clearing after reset: the indices never let an unwritten entry be
// read. Depends on adq_pkg, adq_if, adq_ram, adq_ctrl and adq_dp.
`default_nettype none

module array_double_ended_queue_unit #(
    parameter int DEPTH = adq_pkg::ADQ_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    adq_req_if.sink    i_req,
    adq_rsp_if.source  o_rsp
);
    import adq_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    adq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    adq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_data  (i_req.data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_data  (o_rsp.data)
    );

endmodule

`default_nettype wire
